[hw/rtl/langant_pkg.sv]
// ----------------------------------------------------------------------------
// langant_pkg
// Shared types and constants of the Langton's ant torus block: grid size
// defaults, command and heading codes, register indexes and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

package langant_pkg;

  // Default storage size of the grid.
  localparam int unsigned MAX_ROWS_DEF = 128;
  localparam int unsigned MAX_COLS_DEF = 128;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_WIDTH  = 1'd1;
  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 8'd128;

  // Field widths of the stream items.
  localparam int unsigned POS_W      = 7;
  localparam int unsigned IN_TDATA_W = 16;
  localparam int unsigned IN_TUSER_W = 1;
  localparam int unsigned OUT_TDATA_W = 24;

  // Commands.
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_e;

  // Result item, packed with cell_value in the lowest bit.
  typedef struct packed {
    logic [1:0]       ant_heading;
    logic [POS_W-1:0] ant_col;
    logic [POS_W-1:0] ant_row;
    logic             cell_value;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // Depth of the result queue in front of the master port.
  localparam int unsigned RES_FIFO_DEPTH = 4;

endpackage

`default_nettype wire

[hw/rtl/langton_ant_torus_step_top.sv]
// A result passes through the grid memory read register and the result queue
// before it can be taken. Reads are accepted one per cycle while the queue has
// room; a step holds off the next transaction until the grid memory read and the
// write-back of the ant's cell are done.
// Reset: the grid is cleared one cell a cycle with s_axis_tready low; configuration
// writes are taken at once.
// ----------------------------------------------------------------------------
// langton_ant_torus_step_top
// Langton's ant on a toroidal one-bit grid held in a synchronous memory, with
// step and cell-read commands and a configurable size in use.
// ----------------------------------------------------------------------------
`default_nettype none

module langton_ant_torus_step_top #(
  parameter int unsigned MAX_ROWS = langant_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = langant_pkg::MAX_COLS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration write port.
  input  wire logic                                  cfg_we_i,
  input  wire logic [langant_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [langant_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Command stream.
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // Fields from bit 0: read_row[6:0], read_col[13:7], zero pad[15:14].
  input  wire logic [langant_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: command[0].
  input  wire logic [langant_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // Result stream.
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // Fields from bit 0: cell_value[0], ant_row[7:1], ant_col[14:8],
  // ant_heading[16:15], zero pad[23:17].
  output logic [langant_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned HW    = (RW + 1 > langant_pkg::CFG_DATA_W) ? RW + 1
                                                                     : langant_pkg::CFG_DATA_W;
  localparam int unsigned WW    = (CW + 1 > langant_pkg::CFG_DATA_W) ? CW + 1
                                                                     : langant_pkg::CFG_DATA_W;
  localparam int unsigned XW    = AW + langant_pkg::POS_W + 1;
  localparam int unsigned FD    = langant_pkg::RES_FIFO_DEPTH;
  localparam int unsigned FCW   = $clog2(FD + 1);
  localparam int unsigned PW    = langant_pkg::POS_W;

  // Configuration registers.
  logic [langant_pkg::CFG_DATA_W-1:0] cfg_h_q, cfg_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q <= langant_pkg::GRID_SIZE_RESET;
      cfg_w_q <= langant_pkg::GRID_SIZE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == langant_pkg::REG_GRID_HEIGHT) begin
        cfg_h_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == langant_pkg::REG_GRID_WIDTH) begin
        cfg_w_q <= cfg_wdata_i;
      end
    end
  end

  // Size in use: zero acts as one, anything above the storage acts as the storage.
  logic [HW-1:0] h_ext, h_eff;
  logic [WW-1:0] w_ext, w_eff;

  always_comb begin
    h_ext = HW'(cfg_h_q);
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > HW'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = h_ext;
    end
    w_ext = WW'(cfg_w_q);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_COLS)) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = w_ext;
    end
  end

  // Ant state.
  logic [RW-1:0] ant_row_q, ant_row_d;
  logic [CW-1:0] ant_col_q, ant_col_d;
  logic [1:0]    ant_head_q, ant_head_d;

  // Clearing pass.
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // Second stage: memory data is valid here.
  logic          b_valid_q, b_cmd_q, b_oob_q, b_fwd_q, b_fwd_val_q;
  logic [AW-1:0] b_addr_q;
  logic          b_step;

  // Input decode.
  logic          in_cmd;
  logic [PW-1:0] in_row, in_col;
  logic          in_fire, rd_oob;
  logic [AW-1:0] rd_addr, ant_addr, acc_addr;
  logic [FCW-1:0] fifo_cnt;

  assign in_cmd = s_axis_tuser[0];
  assign in_row = s_axis_tdata[PW-1:0];
  assign in_col = s_axis_tdata[2*PW-1:PW];

  assign rd_oob   = (32'(in_row) >= MAX_ROWS) || (32'(in_col) >= MAX_COLS);
  assign rd_addr  = AW'(XW'(in_row) * XW'(MAX_COLS) + XW'(in_col));
  assign ant_addr = AW'(XW'(ant_row_q) * XW'(MAX_COLS) + XW'(ant_col_q));
  assign acc_addr = (in_cmd == langant_pkg::CMD_READ) ? rd_addr : ant_addr;

  assign b_step = b_valid_q && (b_cmd_q == langant_pkg::CMD_STEP);

  // A step in flight holds off the next transaction, since the next step reads
  // the cell this one moves to. Queue credit counts the item in the second stage.
  assign s_axis_tready = !clr_q && !b_step &&
                         ((FCW+1)'(fifo_cnt) + (FCW+1)'(b_valid_q) < (FCW+1)'(FD - 1));
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Grid memory.
  logic          grid_q [DEPTH];
  logic          mem_rdata_q;
  logic          mem_we, mem_wdata;
  logic [AW-1:0] mem_waddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_q[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rdata_q <= grid_q[acc_addr];
    end
  end

  // Cell update and move.
  logic cell_old, cell_new;

  assign cell_old = b_fwd_q ? b_fwd_val_q : mem_rdata_q;
  assign cell_new = ~cell_old;

  always_comb begin
    ant_head_d = cell_old ? ant_head_q - 2'd1 : ant_head_q + 2'd1;
    ant_row_d  = ant_row_q;
    ant_col_d  = ant_col_q;
    case (ant_head_d)
      langant_pkg::HEAD_UP: begin
        ant_row_d = (ant_row_q == '0) ? RW'(h_eff - HW'(1)) : ant_row_q - RW'(1);
      end
      langant_pkg::HEAD_RIGHT: begin
        ant_col_d = (WW'(ant_col_q) + WW'(1) >= w_eff) ? '0 : ant_col_q + CW'(1);
      end
      langant_pkg::HEAD_DOWN: begin
        ant_row_d = (HW'(ant_row_q) + HW'(1) >= h_eff) ? '0 : ant_row_q + RW'(1);
      end
      langant_pkg::HEAD_LEFT: begin
        ant_col_d = (ant_col_q == '0) ? CW'(w_eff - WW'(1)) : ant_col_q - CW'(1);
      end
      default: begin
        ant_row_d = ant_row_q;
      end
    endcase
  end

  assign mem_we    = clr_q || b_step;
  assign mem_waddr = clr_q ? clr_addr_q : b_addr_q;
  assign mem_wdata = clr_q ? 1'b0 : cell_new;

  langant_pkg::res_t res;

  always_comb begin
    if (b_cmd_q == langant_pkg::CMD_STEP) begin
      res.cell_value  = cell_new;
      res.ant_row     = PW'(ant_row_d);
      res.ant_col     = PW'(ant_col_d);
      res.ant_heading = ant_head_d;
    end else begin
      res.cell_value  = b_oob_q ? 1'b0 : cell_old;
      res.ant_row     = PW'(ant_row_q);
      res.ant_col     = PW'(ant_col_q);
      res.ant_heading = ant_head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      b_valid_q  <= 1'b0;
      ant_row_q  <= '0;
      ant_col_q  <= '0;
      ant_head_q <= langant_pkg::HEAD_UP;
    end else begin
      if (clr_q) begin
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
      end
      b_valid_q <= in_fire;
      if (b_step) begin
        ant_row_q  <= ant_row_d;
        ant_col_q  <= ant_col_d;
        ant_head_q <= ant_head_d;
      end
    end
  end

  // A read issued while a step writes the same cell sees the old memory
  // contents, so the written value is carried along instead.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_cmd_q     <= in_cmd;
      b_oob_q     <= (in_cmd == langant_pkg::CMD_READ) && rd_oob;
      b_addr_q    <= acc_addr;
      b_fwd_q     <= (in_cmd == langant_pkg::CMD_READ) && b_step && (b_addr_q == rd_addr);
      b_fwd_val_q <= cell_new;
    end
  end

  langant_pkg::res_t out_res;

  langant_res_fifo #(
    .DEPTH (FD)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (b_valid_q),
    .push_data_i (res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .count_o     (fifo_cnt)
  );

  assign m_axis_tdata = {(langant_pkg::OUT_TDATA_W - langant_pkg::RES_W)'(0), out_res};

endmodule

`default_nettype wire

[hw/rtl/langant_res_fifo.sv]
// ----------------------------------------------------------------------------
// langant_res_fifo
// Small result queue that decouples the grid pipeline from the master port.
// ----------------------------------------------------------------------------
`default_nettype none

module langant_res_fifo #(
  parameter int unsigned DEPTH = langant_pkg::RES_FIFO_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire langant_pkg::res_t             push_data_i,
  input  wire logic                          pop_i,
  output logic                               valid_o,
  output langant_pkg::res_t                  data_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  langant_pkg::res_t buf_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]   cnt_q;
  logic              do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = valid_o && pop_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/langant_checker.sv]
// ----------------------------------------------------------------------------
// langant_port_checks
// Port-level checks of the Langton's ant block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module langant_port_checks (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic [langant_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [langant_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_fire, out_fire;
  logic [3:0] pend_q;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Transactions accepted whose results have not been taken yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_fire && !out_fire) begin
      pend_q <= pend_q + 4'd1;
    end else if (!in_fire && out_fire) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  // A result is never shown without an accepted command behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 4'd0))
    else $error("result presented with no outstanding command");

  // The cell a step moves to is not known yet, so the next cycle accepts nothing.
  a_step_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser[0] == langant_pkg::CMD_STEP)) |=> !s_axis_tready)
    else $error("transaction accepted right after a step");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind langton_ant_torus_step_top langant_port_checks u_langant_port_checks (.*);

`default_nettype wire

[tb/sv/langant_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// langant_checker
// Watches the configuration, command and result ports of the Langton's ant
// block, keeps its own grid, ant and size registers, and compares every
// result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module langant_checker
  import langant_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  // Fields from bit 0: read_row[6:0], read_col[13:7], zero pad[15:14].
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  // Fields from bit 0: command[0].
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  // Fields from bit 0: cell_value[0], ant_row[7:1], ant_col[14:8],
  // ant_heading[16:15], zero pad[23:17].
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                   drain_check_i,
  output int unsigned            pending_o,
  output int unsigned            errors_o,
  output int unsigned            steps_o,
  output int unsigned            reads_o,
  output int unsigned            results_o
);

  localparam int unsigned ROWS = MAX_ROWS_DEF;
  localparam int unsigned COLS = MAX_COLS_DEF;

  logic [COLS-1:0]       grid_q [ROWS];
  int unsigned           ant_row_q;
  int unsigned           ant_col_q;
  heading_e              heading_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic [CFG_DATA_W-1:0] width_q;
  res_t                  expected_results_q [$];
  bit                    drained;

  initial begin
    errors_o  = 0;
    steps_o   = 0;
    reads_o   = 0;
    results_o = 0;
    pending_o = 0;
    drained   = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t MISMATCH %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, results_o);
    errors_o++;
  endtask

  function automatic int unsigned clamp_size(input int unsigned v,
                                             input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Applies one command to the local grid and ant and returns the result
  // the block must produce for it.
  function automatic res_t advance_ant(input logic cmd, input int unsigned rrow,
                                       input int unsigned rcol);
    res_t        r;
    int unsigned h;
    int unsigned w;
    logic        old;
    logic [1:0]  turned;

    r = '0;
    if (cmd == CMD_READ) begin
      if (rrow < ROWS && rcol < COLS)
        r.cell_value = grid_q[rrow[POS_W-1:0]][rcol[POS_W-1:0]];
    end else begin
      h = clamp_size(32'(height_q), ROWS);
      w = clamp_size(32'(width_q), COLS);
      old = grid_q[ant_row_q[POS_W-1:0]][ant_col_q[POS_W-1:0]];
      grid_q[ant_row_q[POS_W-1:0]][ant_col_q[POS_W-1:0]] = ~old;
      r.cell_value = ~old;
      // White turns clockwise, black counterclockwise.
      turned = old ? heading_q - 2'd1 : heading_q + 2'd1;
      heading_q = heading_e'(turned);
      // An ant left outside a shrunk grid wraps to 0 on a step down or right, as it is
      // past the far edge; a step up or left is a plain step unless it leaves 0.
      case (heading_q)
        HEAD_UP:    ant_row_q = (ant_row_q == 0) ? h - 1 : ant_row_q - 1;
        HEAD_RIGHT: ant_col_q = (ant_col_q + 1 >= w) ? 0 : ant_col_q + 1;
        HEAD_DOWN:  ant_row_q = (ant_row_q + 1 >= h) ? 0 : ant_row_q + 1;
        default:    ant_col_q = (ant_col_q == 0) ? w - 1 : ant_col_q - 1;
      endcase
    end
    r.ant_row     = ant_row_q[POS_W-1:0];
    r.ant_col     = ant_col_q[POS_W-1:0];
    r.ant_heading = heading_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;

    if (!rst_ni) begin
      grid_q = '{default: '0};
      ant_row_q = 0;
      ant_col_q = 0;
      heading_q = HEAD_UP;
      height_q  = GRID_SIZE_RESET;
      width_q   = GRID_SIZE_RESET;
      expected_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_GRID_HEIGHT) height_q = cfg_wdata_i;
        else if (cfg_idx_i == REG_GRID_WIDTH) width_q = cfg_wdata_i;
      end

      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[RES_W-1:0]);
        results_o++;
        if (expected_results_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 32'(m_tdata_i), 0);
        end else begin
          want = expected_results_q.pop_front();
          if (got.cell_value != want.cell_value)
            report_mismatch("cell_value", 32'(got.cell_value), 32'(want.cell_value));
          if (got.ant_row != want.ant_row)
            report_mismatch("ant_row", 32'(got.ant_row), 32'(want.ant_row));
          if (got.ant_col != want.ant_col)
            report_mismatch("ant_col", 32'(got.ant_col), 32'(want.ant_col));
          if (got.ant_heading != want.ant_heading)
            report_mismatch("ant_heading", 32'(got.ant_heading), 32'(want.ant_heading));
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == CMD_READ) reads_o++;
        else steps_o++;
        expected_results_q.push_back(advance_ant(s_tuser_i[0],
                                                 32'(s_tdata_i[POS_W-1:0]),
                                                 32'(s_tdata_i[2*POS_W-1:POS_W])));
      end

      if (drain_check_i && !drained) begin
        drained = 1'b1;
        if (expected_results_q.size() != 0)
          report_mismatch("results never delivered", 0, expected_results_q.size());
      end
    end
    pending_o = expected_results_q.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives step and cell-read commands into the Langton's ant block under
// random source and sink stalls, changes the grid size between phases
// (including zero and oversized register values) and takes the verdict from
// the checker that predicts every result.
// ----------------------------------------------------------------------------
module testbench;
  import langant_pkg::*;

  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT     = 800_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned PHASES          = 16;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  localparam int          HOLD_PHASE      = 9;
  localparam int          NO_IDLE_PHASE   = 6;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   drain_check;

  int unsigned pending;
  int unsigned errors;
  int unsigned steps;
  int unsigned reads;
  int unsigned results;
  int unsigned cycle_count = 0;
  int unsigned size_settings = 0;
  int unsigned cur_h = MAX_ROWS_DEF;
  int unsigned cur_w = MAX_COLS_DEF;
  bit          idle_en = 1'b1;
  bit          hold_off_req = 1'b0;

  langton_ant_torus_step_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  langant_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .drain_check_i (drain_check),
    .pending_o     (pending),
    .errors_o      (errors),
    .steps_o       (steps),
    .reads_o       (reads),
    .results_o     (results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("testbench: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result sink: alternates ready runs with stalls; a hold-off request keeps
  // it stalled long enough for the block to back up into its input.
  initial begin
    int unsigned gap;
    m_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Called right after the rising clock; returns right after the transaction
  // was accepted, with tvalid still high.
  task automatic send_item(input logic cmd, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser[0] <= cmd;
    s_tdata    <= {2'b00, col, row};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] h,
                          input logic [CFG_DATA_W-1:0] w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_GRID_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= REG_GRID_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_h = (h == 0) ? 1 : (32'(h) > MAX_ROWS_DEF) ? MAX_ROWS_DEF : 32'(h);
    cur_w = (w == 0) ? 1 : (32'(w) > MAX_COLS_DEF) ? MAX_COLS_DEF : 32'(w);
    size_settings++;
  endtask

  initial begin
    int unsigned h;
    int unsigned w;
    int unsigned pick;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    drain_check = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Fresh grid at the reset size: corners read white, then a short walk
    // that returns to a black origin and wraps left past column 0.
    send_item(CMD_READ, 7'd0, 7'd0);
    send_item(CMD_READ, 7'd127, 7'd127);
    send_item(CMD_READ, 7'd0, 7'd127);
    send_item(CMD_READ, 7'd127, 7'd0);
    repeat (5) send_item(CMD_STEP, 7'd0, 7'd0);
    send_item(CMD_READ, 7'd0, 7'd0);
    send_item(CMD_READ, 7'd0, 7'd1);
    send_item(CMD_READ, 7'd1, 7'd1);
    s_tvalid <= 1'b0;

    // Shrink the grid while the ant sits far outside it.
    wait_idle();
    set_size(8'd3, 8'd2);
    repeat (6) send_item(CMD_STEP, 7'h7f, 7'h7f);
    send_item(CMD_READ, 7'd0, 7'd127);
    s_tvalid <= 1'b0;

    // Zero sizes act as a single cell.
    wait_idle();
    set_size(8'd0, 8'd0);
    repeat (4) send_item(CMD_STEP, 7'd0, 7'd0);
    s_tvalid <= 1'b0;

    // Oversized values clamp to the storage size.
    wait_idle();
    set_size(8'd255, 8'd129);
    repeat (2) send_item(CMD_STEP, 7'd0, 7'd0);
    s_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin h = 1;   w = 1;   end
        1: begin h = 128; w = 128; end
        2: begin h = 255; w = 0;   end
        3: begin h = 0;   w = 255; end
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            h = $urandom_range(1, 12);
            w = $urandom_range(1, 12);
          end else begin
            h = $urandom_range(0, 255);
            w = $urandom_range(0, 255);
          end
        end
      endcase
      // The sender stays quiet here until every result has come back.
      wait_idle();
      set_size(CFG_DATA_W'(h), CFG_DATA_W'(w));
      idle_en = (p != NO_IDLE_PHASE) && (p != HOLD_PHASE);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)
          send_item(CMD_STEP, POS_W'($urandom_range(0, 127)),
                    POS_W'($urandom_range(0, 127)));
        else if (pick < 90)
          send_item(CMD_READ, POS_W'($urandom_range(0, cur_h - 1)),
                    POS_W'($urandom_range(0, cur_w - 1)));
        else
          send_item(CMD_READ, POS_W'($urandom_range(0, 127)),
                    POS_W'($urandom_range(0, 127)));
      end
      s_tvalid <= 1'b0;
    end
    idle_en = 1'b1;

    wait_idle();
    drain_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("checked %0d results for %0d step and %0d read commands", results, steps, reads);
    $display("across %0d grid size settings, zero and oversized values included",
             size_settings);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[langton_ant_torus_step_top.f]
hw/rtl/langant_pkg.sv
hw/rtl/langant_res_fifo.sv
hw/rtl/langton_ant_torus_step_top.sv
hw/rtl/langant_checker.sv
tb/sv/langant_checker.sv
tb/sv/testbench.sv
